// ===== rtl/dtbs_pkg.sv =====
// dtbs_pkg: types, codes and pin sequence tables for the DDS tuning sequencer.
// Used by dds_tune_bitbang_sequencer and its checker; no dependencies.

package dtbs_pkg;

    localparam int TUNING_BITS_DEF = 28;

    localparam logic [26:0] MCLK_HZ    = 27'd75000000;
    localparam logic [8:0]  SET_LEN    = 9'd308;
    localparam logic [8:0]  SLEEP_LEN  = 9'd38;
    localparam logic [15:0] SLEEP_WORD = 16'h21f8;

    localparam logic [15:0] CTRL_LOW   = 16'h2028;
    localparam logic [15:0] CTRL_MID   = 16'h2038;
    localparam logic [15:0] CTRL_RESET = 16'h0100;
    localparam logic [15:0] FREQ0_SEL  = 16'h4000;
    localparam logic [15:0] FREQ1_SEL  = 16'h8000;
    localparam logic [15:0] PHASE_FIRST = 16'hc000;
    localparam logic [15:0] PHASE_WORD = 16'he000;
    localparam logic [13:0] HALF_MASK  = 14'h3fff;

    localparam logic [26:0] MIN_FREQ_RST = 27'd1000;
    localparam logic [26:0] MAX_FREQ_RST = 27'd70000000;

    localparam logic [7:0] LED_BIT = 8'h08;

    // band filter codes, thresholds on the unhalved frequency
    localparam logic [7:0] BAND_0 = 8'h10;
    localparam logic [7:0] BAND_1 = 8'hB0;
    localparam logic [7:0] BAND_2 = 8'hC0;
    localparam logic [7:0] BAND_3 = 8'h60;
    localparam logic [7:0] BAND_4 = 8'h00;
    localparam logic [7:0] BAND_5 = 8'hD0;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_SLEEP = 2'd2,
        ACT_REARM = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RANGE = 2'd2,
        ST_BUSY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_MIN_FREQ = 2'd0,
        REG_MAX_FREQ = 2'd1,
        REG_HALVE    = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [26:0] frequency;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pin_byte;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    localparam int NUM_SEGS = 18;

    // framing patterns: SCLK bit0, data bit1, FSYNC bit2
    localparam logic [2:0] FRAME_BYTES [4][7] = '{
        '{3'd5, 3'd5, 3'd5, 3'd5, 3'd1, 3'd0, 3'd0},
        '{3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1},
        '{3'd5, 3'd5, 3'd5, 3'd1, 3'd0, 3'd0, 3'd0},
        '{3'd5, 3'd5, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    // bit3 set: data word (low bits give its number), else framing pattern
    localparam logic [3:0] SEG_CODE [NUM_SEGS] = '{
        4'd0, 4'd0, 4'd8, 4'd1, 4'd9, 4'd0, 4'd10, 4'd1, 4'd11,
        4'd0, 4'd12, 4'd1, 4'd13, 4'd2, 4'd14, 4'd2, 4'd15, 4'd3
    };

    localparam logic [8:0] SEG_START [NUM_SEGS] = '{
        9'd0, 9'd5, 9'd10, 9'd42, 9'd49, 9'd81, 9'd86, 9'd118, 9'd125,
        9'd157, 9'd162, 9'd194, 9'd201, 9'd233, 9'd237, 9'd269, 9'd273, 9'd305
    };

    // two bytes per word bit, MSB first; clock low on the odd byte
    function automatic logic [1:0] word_bit(input logic [15:0] val, input logic [4:0] k);
        logic b;
        b = val[4'd15 - k[4:1]];
        return {b, ~k[0]};
    endfunction

    function automatic logic [15:0] data_word(input logic [2:0] n, input logic mid,
                                              input logic first_wr, input logic [31:0] tw);
        logic [15:0] ctrl;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] w;
        ctrl = mid ? CTRL_MID : CTRL_LOW;
        lo   = {2'b00, tw[13:0] & HALF_MASK};
        hi   = {2'b00, tw[27:14] & HALF_MASK};
        case (n)
            3'd0:    w = first_wr ? (ctrl | CTRL_RESET) : ctrl;
            3'd1:    w = FREQ0_SEL | lo;
            3'd2:    w = FREQ0_SEL | hi;
            3'd3:    w = FREQ1_SEL | lo;
            3'd4:    w = FREQ1_SEL | hi;
            3'd5:    w = first_wr ? PHASE_FIRST : PHASE_WORD;
            3'd6:    w = PHASE_WORD;
            default: w = ctrl;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] sleep_byte(input logic [8:0] idx);
        logic [7:0] b;
        logic [8:0] k;
        k = idx - 9'd5;
        if (idx < 9'd4)
            b = 8'd5;
        else if (idx == 9'd4)
            b = 8'd1;
        else if (idx < 9'd37)
            b = {6'b0, word_bit(SLEEP_WORD, k[4:0])};
        else
            b = 8'd5;
        return b;
    endfunction

endpackage

// ===== rtl/dds_tune_bitbang_sequencer.sv =====
// dds_tune_bitbang_sequencer: pin byte sequencer for loading a DDS tuning word.
// Depends on dtbs_pkg.
//
//  channel | dir | handshake             | beat
//  --------+-----+-----------------------+----------------------------------
//  in      | in  | in_valid / in_ready   | in_item_t: action, frequency
//  out     | out | out_valid / out_ready | out_item_t: pin_byte, status, last
//  cfg     | in  | APB, pready tied high | min/max frequency, halve flag
//
// One beat in, one beat out, one beat per cycle sustained; the result sits in
// a single output register and in_ready follows out_ready when it is full.
// The tuning word comes from a reciprocal multiply by the 75 MHz clock constant:
// two 27x27 partial products are registered with the set beat and summed in the
// next cycle, so the word settles long before FREQ0 bits go out at step 49.
// Reset: idle, first-write flag set, limits 1000 Hz .. 70 MHz, halving on.

module dds_tune_bitbang_sequencer
    import dtbs_pkg::*;
#(
    parameter int TUNING_BITS = TUNING_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // floor(d * 2^TUNING_BITS / MCLK) == (d * RECIP) >> 48, exact for 27-bit d
    // since d times the odd part of the clock stays below 2^48
    localparam int          RECIP_SHIFT = 48;
    localparam logic [80:0] RECIP_FULL  =
        ((81'd1 << (TUNING_BITS + RECIP_SHIFT)) + 81'(MCLK_HZ) - 81'd1) / 81'(MCLK_HZ);
    localparam logic [26:0] RECIP_LO    = RECIP_FULL[26:0];
    localparam logic [26:0] RECIP_HI    = RECIP_FULL[53:27];

    logic [26:0] min_freq_reg, max_freq_reg;
    logic        halve_reg;

    logic        running_reg, running_next;
    logic [8:0]  step_reg, step_next;
    logic        sleep_reg, sleep_next;
    logic        mid_reg, mid_next;
    logic [7:0]  band_reg, band_next;
    logic        led_reg, led_next;
    logic        fw_pend_reg, fw_pend_next;
    logic        fw_latch_reg, fw_latch_next;

    logic [TUNING_BITS-1:0] tw_reg, tw_next;
    logic [53:0]            prod_lo_reg, prod_lo_next;
    logic [53:0]            prod_hi_reg, prod_hi_next;
    logic [80:0]            prod_sum;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic        accept;
    logic        cfg_wr;
    logic [26:0] dval;

    logic        emit, start;
    logic [8:0]  idx, len;
    logic [4:0]  seg;
    logic [8:0]  off_full;
    logic [3:0]  code;
    logic [7:0]  base, set_b;
    logic [31:0] tw32;

    assign accept    = in_valid & in_ready;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite;
    assign tw32      = 32'(tw_reg);

    always_comb
    begin
        case (paddr[3:2])
            REG_MIN_FREQ: prdata = {5'b0, min_freq_reg};
            REG_MAX_FREQ: prdata = {5'b0, max_freq_reg};
            REG_HALVE:    prdata = {31'b0, halve_reg};
            default:      prdata = 32'b0;
        endcase
    end

    // command decode, then emission from the updated state
    always_comb
    begin
        running_next  = running_reg;
        step_next     = step_reg;
        sleep_next    = sleep_reg;
        mid_next      = mid_reg;
        band_next     = band_reg;
        led_next      = led_reg;
        fw_pend_next  = fw_pend_reg;
        fw_latch_next = fw_latch_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_data_next  = out_data_reg;
        emit  = 1'b0;
        start = 1'b0;
        dval  = halve_reg ? {1'b0, in_data.frequency[26:1]} : in_data.frequency;

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '{pin_byte: 8'd0, status: ST_IDLE, last: 1'b0};
            case (action_t'(in_data.action))
                ACT_TICK:
                begin
                    emit = running_reg;
                end
                ACT_REARM:
                begin
                    fw_pend_next = 1'b1;
                end
                ACT_SLEEP:
                begin
                    if (running_reg)
                        out_data_next.status = ST_BUSY;
                    else
                    begin
                        sleep_next = 1'b1;
                        start      = 1'b1;
                        emit       = 1'b1;
                    end
                end
                ACT_SET:
                begin
                    if (running_reg)
                        out_data_next.status = ST_BUSY;
                    else if (in_data.frequency < min_freq_reg ||
                             in_data.frequency > max_freq_reg)
                        out_data_next.status = ST_RANGE;
                    else
                    begin
                        if (in_data.frequency < 27'd1200000)       band_next = BAND_0;
                        else if (in_data.frequency < 27'd5500000)  band_next = BAND_1;
                        else if (in_data.frequency < 27'd10500000) band_next = BAND_2;
                        else if (in_data.frequency < 27'd18500000) band_next = BAND_3;
                        else if (in_data.frequency < 27'd30000000) band_next = BAND_4;
                        else                                       band_next = BAND_5;
                        mid_next = (in_data.frequency >= 27'd1600000) &&
                                   (in_data.frequency <= 27'd19000000);
                        fw_latch_next = fw_pend_reg;
                        fw_pend_next  = 1'b0;
                        led_next      = ~led_reg;
                        sleep_next    = 1'b0;
                        start         = 1'b1;
                        emit          = 1'b1;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        len = sleep_next ? SLEEP_LEN : SET_LEN;
        idx = start ? 9'd0 : step_reg;
        if (idx >= len)
            idx = len - 9'd1;

        seg = 5'd0;
        for (int s = 1; s < NUM_SEGS; s++)
        begin
            if (idx >= SEG_START[s])
                seg = 5'(s);
        end
        off_full = idx - SEG_START[seg];
        code     = SEG_CODE[seg];
        if (code[3])
            base = {6'b0, word_bit(data_word(code[2:0], mid_next, fw_latch_next, tw32),
                                   off_full[4:0])};
        else
            base = {5'b0, FRAME_BYTES[code[1:0]][off_full[2:0]]};
        set_b = base | (led_next ? 8'd0 : LED_BIT) | band_next;

        if (emit)
        begin
            out_data_next.pin_byte = sleep_next ? sleep_byte(idx) : set_b;
            out_data_next.status   = ST_BYTE;
            out_data_next.last     = (idx + 9'd1 >= len);
            running_next = 1'b1;
            if (idx + 9'd1 >= len)
            begin
                running_next = 1'b0;
                step_next    = 9'd0;
            end
            else
                step_next = idx + 9'd1;
        end
    end

    // partial products taken with the set beat, low TUNING_BITS of the quotient kept
    always_comb
    begin
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        if (start && !sleep_next)
        begin
            prod_lo_next = {27'b0, dval} * {27'b0, RECIP_LO};
            prod_hi_next = {27'b0, dval} * {27'b0, RECIP_HI};
        end
    end

    assign prod_sum = {prod_hi_reg, 27'b0} + {27'b0, prod_lo_reg};
    assign tw_next  = prod_sum[RECIP_SHIFT +: TUNING_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg  <= MIN_FREQ_RST;
            max_freq_reg  <= MAX_FREQ_RST;
            halve_reg     <= 1'b1;
            running_reg   <= 1'b0;
            step_reg      <= 9'd0;
            sleep_reg     <= 1'b0;
            mid_reg       <= 1'b0;
            band_reg      <= 8'd0;
            led_reg       <= 1'b0;
            fw_pend_reg   <= 1'b1;
            fw_latch_reg  <= 1'b0;
            tw_reg        <= '0;
            prod_lo_reg   <= 54'd0;
            prod_hi_reg   <= 54'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_MIN_FREQ: min_freq_reg <= pwdata[26:0];
                    REG_MAX_FREQ: max_freq_reg <= pwdata[26:0];
                    REG_HALVE:    halve_reg    <= pwdata[0];
                    default:      halve_reg    <= halve_reg;
                endcase
            end
            running_reg   <= running_next;
            step_reg      <= step_next;
            sleep_reg     <= sleep_next;
            mid_reg       <= mid_next;
            band_reg      <= band_next;
            led_reg       <= led_next;
            fw_pend_reg   <= fw_pend_next;
            fw_latch_reg  <= fw_latch_next;
            tw_reg        <= tw_next;
            prod_lo_reg   <= prod_lo_next;
            prod_hi_reg   <= prod_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/dtbs_checker.sv =====
// dtbs_checker: port-level assertions for dds_tune_bitbang_sequencer, bound to it.
// Depends on dtbs_pkg.

module dtbs_checker
    import dtbs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // no byte and no last flag unless the status says a byte is valid
    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_BYTE |->
            out_data.pin_byte == 8'd0 && !out_data.last)
        else $error("pin byte or last set on a non-byte result");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // rearm always answers idle in the next cycle
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_REARM |=>
            out_valid && out_data.status == ST_IDLE)
        else $error("rearm did not answer idle");

endmodule

bind dds_tune_bitbang_sequencer dtbs_checker u_dtbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
